// ===== rtl/fbp_pkg.sv =====
// Shared types and constants for the fuzzy brake pressure block.
// Leaf package: no dependencies.
package fbp_pkg;

  localparam int LEVEL_W    = 7;
  localparam int IN_W       = 8;
  localparam int PRESSURE_W = 15;
  localparam int WEIGHT_W   = 13;
  localparam int OUT_FRAC   = 8;
  localparam int N_DIST     = 5;
  localparam int N_SPEED    = 4;
  localparam int N_LEVEL    = 4;

  typedef enum logic [1:0] {
    LVL_NONE   = 2'd0,
    LVL_LIGHT  = 2'd1,
    LVL_MEDIUM = 2'd2,
    LVL_STRONG = 2'd3
  } lvl_e_t;

  typedef lvl_e_t grid_row_t [N_SPEED];

  localparam grid_row_t RULE_GRID [N_DIST] = '{
    '{LVL_NONE, LVL_MEDIUM, LVL_STRONG, LVL_STRONG},
    '{LVL_NONE, LVL_LIGHT,  LVL_STRONG, LVL_STRONG},
    '{LVL_NONE, LVL_LIGHT,  LVL_STRONG, LVL_STRONG},
    '{LVL_NONE, LVL_NONE,   LVL_MEDIUM, LVL_MEDIUM},
    '{LVL_NONE, LVL_NONE,   LVL_LIGHT,  LVL_LIGHT}
  };

endpackage

// ===== rtl/fuzzy_brake_pressure_top.sv =====
// Top level of the fuzzy brake pressure block: config registers and pipeline.
// Depends on fbp_pkg, fbp_fuzzify, fbp_rules and fbp_div.
//
// One distance/speed word is taken every cycle; busy never rises and
// cfg_ready is always high. Each word gives one result on out_strobe
// after fuzzification, rule evaluation and accumulation stages, a divider
// input register and a 15-stage divider that settles one quotient bit per
// stage. Results cannot be held off by the receiver. No clearing pass after reset.
// Write the level registers only while idle.
module fuzzy_brake_pressure_top import fbp_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [IN_W-1:0]       in_distance,
  input  logic [IN_W-1:0]       in_speed,
  output logic                  out_strobe,
  output logic [PRESSURE_W-1:0] out_pressure,
  output logic [WEIGHT_W-1:0]   out_total_weight,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [LEVEL_W-1:0]    cfg_data
);

  localparam int MW  = FRACTION_BITS + 1;
  localparam int TW  = MW + 5;
  localparam int AW  = TW + LEVEL_W + 2;
  localparam int LAT = 7 + PRESSURE_W;

  logic [LEVEL_W-1:0] lvl_r [N_LEVEL];
  logic [MW-1:0]      dm [N_DIST];
  logic [MW-1:0]      sm [N_SPEED];
  logic               mem_vld;
  logic               acc_vld;
  logic [TW-1:0]      total;
  logic [AW-1:0]      acc;
  logic               in_vld;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_vld    = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r[LVL_NONE]   <= LEVEL_W'(1);
      lvl_r[LVL_LIGHT]  <= LEVEL_W'(15);
      lvl_r[LVL_MEDIUM] <= LEVEL_W'(45);
      lvl_r[LVL_STRONG] <= LEVEL_W'(80);
    end else if (cfg_valid && cfg_ready) begin
      unique case (lvl_e_t'(cfg_index))
        LVL_NONE:   lvl_r[LVL_NONE]   <= cfg_data;
        LVL_LIGHT:  lvl_r[LVL_LIGHT]  <= cfg_data;
        LVL_MEDIUM: lvl_r[LVL_MEDIUM] <= cfg_data;
        LVL_STRONG: lvl_r[LVL_STRONG] <= cfg_data;
        default:    ;
      endcase
    end
  end

  fbp_fuzzify #(.FRACTION_BITS(FRACTION_BITS)) u_fuzz (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld),
    .distance (in_distance),
    .speed    (in_speed),
    .mem_vld  (mem_vld),
    .dm       (dm),
    .sm       (sm)
  );

  fbp_rules #(.FRACTION_BITS(FRACTION_BITS)) u_rules (
    .clk     (clk),
    .rst_n   (rst_n),
    .mem_vld (mem_vld),
    .dm      (dm),
    .sm      (sm),
    .lvl     (lvl_r),
    .acc_vld (acc_vld),
    .total   (total),
    .acc     (acc)
  );

  fbp_div #(.AW(AW), .TW(TW)) u_div (
    .clk              (clk),
    .rst_n            (rst_n),
    .acc_vld          (acc_vld),
    .acc              (acc),
    .total            (total),
    .out_strobe       (out_strobe),
    .out_pressure     (out_pressure),
    .out_total_weight (out_total_weight)
  );

  a_latency_hit: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_strobe)
    else $error("result missing after accepted word");

  a_latency_none: assert property (@(posedge clk) disable iff (!rst_n)
    !start |-> ##LAT !out_strobe)
    else $error("result without accepted word");

  a_pressure_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_pressure <= PRESSURE_W'(127 * 256))
    else $error("pressure above largest level");

endmodule

// ===== rtl/fbp_fuzzify.sv =====
// Input register and membership stage: distance and speed to Q1.F memberships.
// Depends on fbp_pkg.
module fbp_fuzzify import fbp_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  logic [IN_W-1:0]          distance,
  input  logic [IN_W-1:0]          speed,
  output logic                     mem_vld,
  output logic [FRACTION_BITS:0]   dm [N_DIST],
  output logic [FRACTION_BITS:0]   sm [N_SPEED]
);

  localparam int MW  = FRACTION_BITS + 1;
  localparam int ONE = 1 << FRACTION_BITS;

  logic            vld_r;
  logic [IN_W-1:0] d_r;
  logic [IN_W-1:0] v_r;
  logic [MW-1:0]   r10 [11];
  logic [MW-1:0]   r25 [26];
  logic [MW-1:0]   r20 [21];
  logic [MW-1:0]   dm_nxt [N_DIST];
  logic [MW-1:0]   sm_nxt [N_SPEED];
  logic [MW-1:0]   dm_r [N_DIST];
  logic [MW-1:0]   sm_r [N_SPEED];
  logic            mvld_r;
  logic [IN_W:0]   d2;
  logic [IN_W:0]   v2;

  for (genvar k = 0; k < 11; k++) begin : g_r10
    assign r10[k] = MW'((k * ONE + 5) / 10);
  end
  for (genvar k = 0; k < 26; k++) begin : g_r25
    assign r25[k] = MW'((k * ONE + 12) / 25);
  end
  for (genvar k = 0; k < 21; k++) begin : g_r20
    assign r20[k] = MW'((k * ONE + 10) / 20);
  end

  function automatic logic [4:0] tri_num(input logic [IN_W:0] x2, input logic [IN_W:0] a2,
                                         input logic [IN_W:0] p2, input logic [IN_W:0] b2);
    logic [IN_W:0] xf;
    xf = '0;
    if (x2 <= a2 || x2 >= b2) begin
      return 5'd0;
    end
    xf = (x2 > p2) ? ((p2 << 1) - x2) : x2;
    return 5'(xf - a2);
  endfunction

  function automatic logic [4:0] rise_num(input logic [IN_W:0] x2, input logic [IN_W:0] a2);
    if (x2 <= a2) begin
      return 5'd0;
    end
    return 5'(x2 - a2);
  endfunction

  always_comb begin
    d2 = {d_r, 1'b0};
    v2 = {v_r, 1'b0};
    sm_nxt[0] = (v_r < IN_W'(2)) ? MW'(ONE) : '0;
    sm_nxt[1] = r10[4'(tri_num(v2, 9'd0, 9'd10, 9'd20))];
    sm_nxt[2] = r25[tri_num(v2, 9'd10, 9'd35, 9'd60)];
    sm_nxt[3] = (v2 >= 9'd75) ? MW'(ONE) : r25[rise_num(v2, 9'd50)];
    dm_nxt[0] = (d_r < IN_W'(2)) ? MW'(ONE) : '0;
    dm_nxt[1] = r10[4'(tri_num(d2, 9'd0, 9'd10, 9'd20))];
    dm_nxt[2] = r25[tri_num(d2, 9'd10, 9'd35, 9'd60)];
    dm_nxt[3] = r20[tri_num(d2, 9'd40, 9'd60, 9'd80)];
    dm_nxt[4] = (d2 >= 9'd80) ? MW'(ONE) : r20[rise_num(d2, 9'd60)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      mvld_r <= 1'b0;
    end else begin
      vld_r  <= in_vld;
      mvld_r <= vld_r;
    end
    d_r  <= distance;
    v_r  <= speed;
    dm_r <= dm_nxt;
    sm_r <= sm_nxt;
  end

  assign mem_vld = mvld_r;
  assign dm      = dm_r;
  assign sm      = sm_r;

endmodule

// ===== rtl/fbp_rules.sv =====
// Rule grid: cell strengths, per-level sums, level products and accumulation.
// Depends on fbp_pkg.
module fbp_rules import fbp_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           mem_vld,
  input  logic [FRACTION_BITS:0]         dm [N_DIST],
  input  logic [FRACTION_BITS:0]         sm [N_SPEED],
  input  logic [LEVEL_W-1:0]             lvl [N_LEVEL],
  output logic                           acc_vld,
  output logic [FRACTION_BITS+5:0]       total,
  output logic [FRACTION_BITS+LEVEL_W+7:0] acc
);

  localparam int MW = FRACTION_BITS + 1;
  localparam int TW = MW + 5;
  localparam int PW = TW + LEVEL_W;
  localparam int AW = PW + 2;

  logic [MW-1:0] cell_nxt [N_DIST][N_SPEED];
  logic [MW-1:0] cell_r   [N_DIST][N_SPEED];
  logic [TW-1:0] wsum_nxt [N_LEVEL];
  logic [TW-1:0] wsum_r   [N_LEVEL];
  logic [TW-1:0] tot_nxt;
  logic [TW-1:0] tot1_r;
  logic [TW-1:0] tot2_r;
  logic [TW-1:0] tot3_r;
  logic [PW-1:0] prod_r   [N_LEVEL];
  logic [AW-1:0] acc_r;
  logic [2:0]    vld_r;
  logic          avld_r;

  always_comb begin
    for (int i = 0; i < N_DIST; i++) begin
      for (int j = 0; j < N_SPEED; j++) begin
        cell_nxt[i][j] = (dm[i] < sm[j]) ? dm[i] : sm[j];
      end
    end
  end

  always_comb begin
    tot_nxt = '0;
    for (int k = 0; k < N_LEVEL; k++) begin
      wsum_nxt[k] = '0;
      for (int i = 0; i < N_DIST; i++) begin
        for (int j = 0; j < N_SPEED; j++) begin
          if (RULE_GRID[i][j] == lvl_e_t'(k)) begin
            wsum_nxt[k] = wsum_nxt[k] + TW'(cell_r[i][j]);
          end
        end
      end
      tot_nxt = tot_nxt + wsum_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      avld_r <= 1'b0;
    end else begin
      vld_r  <= {vld_r[1:0], mem_vld};
      avld_r <= vld_r[2];
    end
    cell_r <= cell_nxt;
    wsum_r <= wsum_nxt;
    tot1_r <= tot_nxt;
    for (int k = 0; k < N_LEVEL; k++) begin
      prod_r[k] <= PW'(wsum_r[k] * lvl[k]);
    end
    tot2_r <= tot1_r;
    acc_r  <= AW'(prod_r[0]) + AW'(prod_r[1]) + AW'(prod_r[2]) + AW'(prod_r[3]);
    tot3_r <= tot2_r;
  end

  assign acc_vld = avld_r;
  assign total   = tot3_r;
  assign acc     = acc_r;

endmodule

// ===== rtl/fbp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with rounding.
// Depends on fbp_pkg.
module fbp_div import fbp_pkg::*; #(
  parameter int AW = 24,
  parameter int TW = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc_vld,
  input  logic [AW-1:0]         acc,
  input  logic [TW-1:0]         total,
  output logic                  out_strobe,
  output logic [PRESSURE_W-1:0] out_pressure,
  output logic [WEIGHT_W-1:0]   out_total_weight
);

  localparam int QW = PRESSURE_W;
  localparam int CW = AW + OUT_FRAC + QW;

  logic [CW-1:0] rem_r [QW+1];
  logic [TW-1:0] den_r [QW+1];
  logic [QW-1:0] quo_r [QW+1];
  logic          vld_r [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= acc_vld;
    end
    rem_r[0] <= (CW'(acc) << OUT_FRAC) + CW'(total >> 1);
    den_r[0] <= total;
    quo_r[0] <= '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [CW-1:0] sub;
    logic          take;
    assign sub  = CW'(den_r[k]) << (QW - 1 - k);
    assign take = (den_r[k] != '0) && (rem_r[k] >= sub);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      rem_r[k+1] <= take ? (rem_r[k] - sub) : rem_r[k];
      den_r[k+1] <= den_r[k];
      quo_r[k+1] <= {quo_r[k][QW-2:0], take};
    end
  end

  assign out_strobe       = vld_r[QW];
  assign out_pressure     = quo_r[QW];
  assign out_total_weight = WEIGHT_W'(den_r[QW]);

endmodule

// ===== test/fuzzy_brake_pressure_top_test.sv =====
// Self-checking testbench for fuzzy_brake_pressure_top: distance/speed words in,
// predicted pressure and total weight compared on every result strobe.
// Depends on fbp_pkg and the fuzzy_brake_pressure_top RTL.
module fuzzy_brake_pressure_top_test;
  import fbp_pkg::*;

  localparam int FRAC      = 8;
  localparam int LATENCY   = 22;
  localparam int MAX_CYCLE = 400000;

  typedef struct packed {
    logic [PRESSURE_W-1:0] pressure;
    logic [WEIGHT_W-1:0]   weight;
  } brake_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [IN_W-1:0] in_distance = '0;
  logic [IN_W-1:0] in_speed = '0;
  logic out_strobe;
  logic [PRESSURE_W-1:0] out_pressure;
  logic [WEIGHT_W-1:0] out_total_weight;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [LEVEL_W-1:0] cfg_data = '0;

  logic [LEVEL_W-1:0] level_tab [N_LEVEL];
  brake_word_t pending_brake [$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  fuzzy_brake_pressure_top #(.FRACTION_BITS(FRAC)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_distance(in_distance), .in_speed(in_speed),
    .out_strobe(out_strobe), .out_pressure(out_pressure),
    .out_total_weight(out_total_weight),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic longint unsigned slope(longint unsigned num, longint unsigned den);
    return ((num << FRAC) + den / 2) / den;
  endfunction

  function automatic longint unsigned peak(int x2, int a2, int p2, int b2);
    int x;
    x = x2;
    if (x <= a2 || x >= b2) return 0;
    if (x > p2) x = 2 * p2 - x;
    return slope(x - a2, p2 - a2);
  endfunction

  function automatic longint unsigned shoulder(int x2, int a2, int p2);
    if (x2 >= p2) return longint'(1) << FRAC;
    if (x2 <= a2) return 0;
    return slope(x2 - a2, p2 - a2);
  endfunction

  function automatic brake_word_t brake_pressure(logic [IN_W-1:0] dst, logic [IN_W-1:0] spd);
    longint unsigned dm [N_DIST];
    longint unsigned sm [N_SPEED];
    longint unsigned total, acc, s, p;
    brake_word_t r;
    total = 0;
    acc = 0;
    p = 0;
    sm[0] = (spd < 2) ? (longint'(1) << FRAC) : 0;
    sm[1] = peak(2 * spd, 0, 10, 20);
    sm[2] = peak(2 * spd, 10, 35, 60);
    sm[3] = shoulder(2 * spd, 50, 75);
    dm[0] = (dst < 2) ? (longint'(1) << FRAC) : 0;
    dm[1] = peak(2 * dst, 0, 10, 20);
    dm[2] = peak(2 * dst, 10, 35, 60);
    dm[3] = peak(2 * dst, 40, 60, 80);
    dm[4] = shoulder(2 * dst, 60, 80);
    for (int i = 0; i < N_DIST; i++)
      for (int j = 0; j < N_SPEED; j++) begin
        s = (dm[i] < sm[j]) ? dm[i] : sm[j];
        total += s;
        acc += s * level_tab[RULE_GRID[i][j]];
      end
    if (total != 0) p = ((acc << OUT_FRAC) + total / 2) / total;
    r.pressure = p[PRESSURE_W-1:0];
    r.weight = total[WEIGHT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    brake_word_t exp_w;
    if (rst_n && start && !busy)
      pending_brake.push_back(brake_pressure(in_distance, in_speed));
    if (rst_n && out_strobe) begin
      if (pending_brake.size() == 0) begin
        $display("%0t: unexpected result pressure=%0d weight=%0d", $time,
                 out_pressure, out_total_weight);
        errors++;
      end else begin
        exp_w = pending_brake.pop_front();
        if (out_pressure !== exp_w.pressure) begin
          $display("%0t: pressure expected %0d actual %0d", $time,
                   exp_w.pressure, out_pressure);
          errors++;
        end
        if (out_total_weight !== exp_w.weight) begin
          $display("%0t: total_weight expected %0d actual %0d", $time,
                   exp_w.weight, out_total_weight);
          errors++;
        end
      end
    end
  end

  task automatic send_word(logic [IN_W-1:0] dst, logic [IN_W-1:0] spd);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_distance <= dst;
    in_speed <= spd;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_brake.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_level(lvl_e_t idx, logic [LEVEL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    level_tab[idx] = val;
    @(negedge clk);
  endtask

  task automatic set_levels(logic [LEVEL_W-1:0] n, logic [LEVEL_W-1:0] l,
                            logic [LEVEL_W-1:0] m, logic [LEVEL_W-1:0] s);
    drain();
    write_level(LVL_NONE, n);
    write_level(LVL_LIGHT, l);
    write_level(LVL_MEDIUM, m);
    write_level(LVL_STRONG, s);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed;
    int pts [] = '{0, 1, 2, 4, 5, 6, 10, 12, 15, 17, 18, 20, 25, 30, 37, 38, 40, 255};
    foreach (pts[k]) send_word(IN_W'(pts[k]), IN_W'(pts[(k * 7) % pts.size()]));
    send_word(8'hff, 8'h00);
    send_word(8'h00, 8'hff);
    send_word(8'haa, 8'h55);
    send_word(8'h55, 8'haa);
    drain();
  endtask

  task automatic test_random(int n, int pct);
    idle_pct = pct;
    repeat (n) begin
      if ($urandom_range(9, 0) < 8)
        send_word(IN_W'($urandom_range(45, 0)), IN_W'($urandom_range(45, 0)));
      else
        send_word(IN_W'($urandom), IN_W'($urandom));
    end
    idle_pct = 0;
  endtask

  task automatic test_levels;
    set_levels(0, 0, 0, 0);
    test_random(60, 0);
    set_levels(127, 127, 127, 127);
    test_random(60, 31);
    set_levels(100, 0, 100, 0);
    test_random(60, 0);
    set_levels(LEVEL_W'($urandom), LEVEL_W'($urandom), LEVEL_W'($urandom),
               LEVEL_W'($urandom));
    test_random(60, 76);
    set_levels(1, 15, 45, 80);
  endtask

  initial begin
    level_tab[LVL_NONE] = 1;
    level_tab[LVL_LIGHT] = 15;
    level_tab[LVL_MEDIUM] = 45;
    level_tab[LVL_STRONG] = 80;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(250, 0);
    test_random(150, 76);
    test_random(150, 31);
    test_levels();
    test_random(100, 0);
    drain();
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
